// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and helpers shared by the strict priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;

    localparam int FIELD_W = 16;
    localparam int CAP_W   = 7;
    localparam int TOTAL_W = 8;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = CNT_W + 1;
    localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SUM_W   = (CNT_W + 1 > TOTAL_W) ? CNT_W + 1 : TOTAL_W;

    localparam logic [FIELD_W-1:0] PORT_EVENT   = FIELD_W'(319);
    localparam logic [FIELD_W-1:0] PORT_GENERAL = FIELD_W'(320);

    typedef enum logic [0:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_ENQUEUED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_DEQUEUED  = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        t_command             command;
        logic [FIELD_W-1:0]   packet_handle;
        logic                 is_udp_in_ipv4;
        logic [FIELD_W-1:0]   udp_dest_port;
    } t_in_word;

    typedef struct packed {
        t_status              status;
        logic [FIELD_W-1:0]   out_handle;
        logic                 out_timing_class;
        logic [TOTAL_W-1:0]   total_length;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic enq_load;
        logic deq_start;
        logic pop_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_dequeue;
    } t_stat;

    function automatic logic [HANDLE_BITS-1:0] to_store(input logic [FIELD_W-1:0] h);
        logic [HANDLE_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < HANDLE_BITS; i++) begin
            if (i < FIELD_W) begin
                r[i] = h[i];
            end
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] from_store(input logic [HANDLE_BITS-1:0] s);
        logic [FIELD_W-1:0] r;
        r = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (i < HANDLE_BITS) begin
                r[i] = s[i];
            end
        end
        return r;
    endfunction

    function automatic logic [TOTAL_W-1:0] total_of(input logic [CNT_W-1:0] a,
                                                     input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'((1 << TOTAL_W) - 1)) begin
            return {TOTAL_W{1'b1}};
        end
        return s[TOTAL_W-1:0];
    endfunction

endpackage

// ----- rtl/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes a word, issues push or pop, owns the result valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd  o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    // the result slot must be free, or be emptied on this edge
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.enq_load  = accept && !i_stat.is_dequeue;
        o_cmd.deq_start = accept && i_stat.is_dequeue;
        o_cmd.pop_load  = (r_state == S_POP);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.enq_load) begin
                    n_out_valid = 1'b1;
                end
                if (o_cmd.deq_start) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/spq_dpath.sv -----
// ----------------------------------------------------------------------------
// spq_dpath
// Class decode, per-class FIFO pointers and stores, limit check, result word.
// ----------------------------------------------------------------------------
module spq_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spq_pkg::t_in_word               i_in_word,
    input  logic                            i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]       i_cfg_data,
    input  spq_pkg::t_cmd                   i_cmd,
    output spq_pkg::t_stat                  o_stat,
    output spq_pkg::t_out_word              o_out_word
);

    logic [spq_pkg::CAP_W-1:0] r_cap;
    logic [spq_pkg::PTR_W-1:0] r_t_head, n_t_head, r_r_head, n_r_head;
    logic [spq_pkg::CNT_W-1:0] r_t_cnt, n_t_cnt, r_r_cnt, n_r_cnt;
    logic                      r_pop_timing, r_pop_any;
    spq_pkg::t_out_word        r_out;

    logic                           is_timing;
    logic [spq_pkg::LIM_W-1:0]      limit;
    logic [spq_pkg::CNT_W-1:0]      cls_cnt;
    logic [spq_pkg::PTR_W-1:0]      cls_head;
    logic [spq_pkg::SLOT_W-1:0]     slot_sum;
    logic [spq_pkg::PTR_W-1:0]      wslot;
    logic                           push_ok;
    logic [spq_pkg::HANDLE_BITS-1:0] store_h;
    logic [spq_pkg::HANDLE_BITS-1:0] t_rdata, r_rdata;
    logic [spq_pkg::CNT_W-1:0]      enq_t_cnt, enq_r_cnt;

    assign o_stat.is_dequeue = (i_in_word.command == spq_pkg::CMD_DEQUEUE);

    assign is_timing = i_in_word.is_udp_in_ipv4 &&
                       (i_in_word.udp_dest_port == spq_pkg::PORT_EVENT ||
                        i_in_word.udp_dest_port == spq_pkg::PORT_GENERAL);

    always_comb begin
        if (r_cap == '0 || spq_pkg::LIM_W'(r_cap) > spq_pkg::LIM_W'(spq_pkg::QUEUE_DEPTH)) begin
            limit = spq_pkg::LIM_W'(spq_pkg::QUEUE_DEPTH);
        end else begin
            limit = spq_pkg::LIM_W'(r_cap);
        end
    end

    assign cls_cnt  = is_timing ? r_t_cnt : r_r_cnt;
    assign cls_head = is_timing ? r_t_head : r_r_head;
    assign push_ok  = spq_pkg::LIM_W'(cls_cnt) < limit;
    assign store_h  = spq_pkg::to_store(i_in_word.packet_handle);

    // tail slot, wraps once since head stays below the depth and count never exceeds it
    always_comb begin
        slot_sum = spq_pkg::SLOT_W'(cls_head) + spq_pkg::SLOT_W'(cls_cnt);
        if (slot_sum >= spq_pkg::SLOT_W'(spq_pkg::QUEUE_DEPTH)) begin
            slot_sum = slot_sum - spq_pkg::SLOT_W'(spq_pkg::QUEUE_DEPTH);
        end
        wslot = slot_sum[spq_pkg::PTR_W-1:0];
    end

    spq_ram #(
        .WIDTH (spq_pkg::HANDLE_BITS),
        .DEPTH (spq_pkg::QUEUE_DEPTH)
    ) u_timing_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_load && push_ok && is_timing),
        .i_waddr (wslot),
        .i_wdata (store_h),
        .i_re    (i_cmd.deq_start),
        .i_raddr (r_t_head),
        .o_rdata (t_rdata)
    );

    spq_ram #(
        .WIDTH (spq_pkg::HANDLE_BITS),
        .DEPTH (spq_pkg::QUEUE_DEPTH)
    ) u_regular_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_load && push_ok && !is_timing),
        .i_waddr (wslot),
        .i_wdata (store_h),
        .i_re    (i_cmd.deq_start),
        .i_raddr (r_r_head),
        .o_rdata (r_rdata)
    );

    always_comb begin
        enq_t_cnt = r_t_cnt;
        enq_r_cnt = r_r_cnt;
        if (push_ok && is_timing) begin
            enq_t_cnt = r_t_cnt + 1'b1;
        end
        if (push_ok && !is_timing) begin
            enq_r_cnt = r_r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_t_head = r_t_head;
        n_r_head = r_r_head;
        n_t_cnt  = r_t_cnt;
        n_r_cnt  = r_r_cnt;
        priority if (i_cmd.enq_load) begin
            n_t_cnt = enq_t_cnt;
            n_r_cnt = enq_r_cnt;
        end else if (i_cmd.deq_start && r_t_cnt != '0) begin
            n_t_cnt  = r_t_cnt - 1'b1;
            n_t_head = (r_t_head == spq_pkg::PTR_W'(spq_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_t_head + 1'b1;
        end else if (i_cmd.deq_start && r_r_cnt != '0) begin
            n_r_cnt  = r_r_cnt - 1'b1;
            n_r_head = (r_r_head == spq_pkg::PTR_W'(spq_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_r_head + 1'b1;
        end else begin
            n_t_cnt = r_t_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= '0;
            r_t_head <= '0;
            r_r_head <= '0;
            r_t_cnt  <= '0;
            r_r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_t_head <= n_t_head;
            r_r_head <= n_r_head;
            r_t_cnt  <= n_t_cnt;
            r_r_cnt  <= n_r_cnt;
        end
    end

    // pop choice and result word carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.deq_start) begin
            r_pop_timing <= (r_t_cnt != '0);
            r_pop_any    <= (r_t_cnt != '0) || (r_r_cnt != '0);
        end
        if (i_cmd.enq_load) begin
            r_out.status           <= push_ok ? spq_pkg::ST_ENQUEUED : spq_pkg::ST_DROPPED;
            r_out.out_handle       <= push_ok ? '0 : spq_pkg::from_store(store_h);
            r_out.out_timing_class <= is_timing;
            r_out.total_length     <= spq_pkg::total_of(enq_t_cnt, enq_r_cnt);
        end else if (i_cmd.pop_load) begin
            // counters already reflect the pop
            r_out.status           <= r_pop_any ? spq_pkg::ST_DEQUEUED : spq_pkg::ST_EMPTY;
            r_out.out_handle       <= !r_pop_any ? '0 :
                                      spq_pkg::from_store(r_pop_timing ? t_rdata : r_rdata);
            r_out.out_timing_class <= r_pop_timing;
            r_out.total_length     <= spq_pkg::total_of(r_t_cnt, r_r_cnt);
        end
    end

    assign o_out_word = r_out;

endmodule

// ----- rtl/ptp_strict_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// ptp_strict_priority_queue_core
// Two-class strict priority packet queue, timing class served before regular.
//
//   channel   direction  handshake                 word
//   in        in         i_in_valid / o_in_ready   t_in_word (enqueue or dequeue)
//   out       out        o_out_valid / i_out_ready t_out_word (one per input word)
//   cfg       in         i_cfg_valid / o_cfg_ready frame_capacity, 7 bits
//
// enqueues sustain one word per cycle while each result is taken in turn
// a dequeue passes through S_POP, where no new word is taken: the class store read is registered before the result
// a new word is taken while a result waits only if that result leaves on the same edge
// synchronous active-low reset clears pointers, counts and capacity; no clearing pass
// ----------------------------------------------------------------------------
module ptp_strict_priority_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  spq_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output spq_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spq_pkg::CAP_W-1:0]     i_cfg_data
);

    spq_pkg::t_cmd  cmd;
    spq_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spq_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule
